// ===== sv/sha1bh_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1bh_pkg
// Shared types, constants and round functions for the byte-serial SHA-1 block
// hash engine.
// ----------------------------------------------------------------------------
package sha1bh_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int ROUNDS      = 80;
	localparam int WORDS       = BLOCK_BYTES / 4;
	localparam int COUNT_W     = $clog2(BLOCK_BYTES);
	localparam int ROUND_W     = $clog2(ROUNDS);
	localparam int PHASE_LEN   = ROUNDS / 4;

	// round phase codes
	localparam logic [1:0] PH_CHOOSE = 2'd0;
	localparam logic [1:0] PH_PARITY = 2'd1;
	localparam logic [1:0] PH_MAJ    = 2'd2;
	localparam logic [1:0] PH_PAR2   = 2'd3;

	// initial chaining values
	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	// round constants
	localparam logic [31:0] K_CHOOSE = 32'h5A827999;
	localparam logic [31:0] K_PARITY = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJ    = 32'h8F1BBCDC;
	localparam logic [31:0] K_PAR2   = 32'hCA62C1D6;

	// controller to datapath commands
	typedef struct packed {
		logic       take;   // accept a message byte
		logic       close;  // this byte closes the block, load working words
		logic       round;  // run one compression round
		logic [1:0] phase;  // round function select
		logic       finish; // add into chain and load the output register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic count_last; // the byte now offered fills the block
	} sts_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] round_k(input logic [1:0] ph);
		case (ph)
			PH_CHOOSE: round_k = K_CHOOSE;
			PH_PARITY: round_k = K_PARITY;
			PH_MAJ:    round_k = K_MAJ;
			default:   round_k = K_PAR2;
		endcase
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] ph, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		case (ph)
			PH_CHOOSE: round_f = (b & c) | (~b & d);
			PH_MAJ:    round_f = (b & c) | (b & d) | (c & d);
			default:   round_f = b ^ c ^ d;
		endcase
	endfunction

endpackage

// ===== sv/sha1bh_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1bh_ctrl
// Controller: byte intake handshake, round sequencing and result hand-off.
// ----------------------------------------------------------------------------
module sha1bh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               message_end,
	output logic               out_valid,
	input  logic               out_ready,
	input  sha1bh_pkg::sts_t   sts,
	output sha1bh_pkg::cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;

	localparam logic [sha1bh_pkg::ROUND_W-1:0] LAST_ROUND =
		sha1bh_pkg::ROUND_W'(sha1bh_pkg::ROUNDS - 1);
	localparam logic [sha1bh_pkg::ROUND_W-1:0] PH1_START =
		sha1bh_pkg::ROUND_W'(sha1bh_pkg::PHASE_LEN);
	localparam logic [sha1bh_pkg::ROUND_W-1:0] PH2_START =
		sha1bh_pkg::ROUND_W'(2 * sha1bh_pkg::PHASE_LEN);
	localparam logic [sha1bh_pkg::ROUND_W-1:0] PH3_START =
		sha1bh_pkg::ROUND_W'(3 * sha1bh_pkg::PHASE_LEN);

	logic [1:0]                        state_q;
	logic [sha1bh_pkg::ROUND_W-1:0]    round_q;
	logic                              out_valid_q;
	logic                              take;
	logic                              close;
	logic                              finish;
	logic [1:0]                        phase;

	// request intake only between compressions
	assign in_ready  = (state_q == ST_IDLE);
	assign take      = in_valid && in_ready;
	assign close     = take && (message_end || sts.count_last);
	assign finish    = (state_q == ST_ADD) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// round phase from the round counter
	always_comb begin
		if (round_q < PH1_START) begin
			phase = sha1bh_pkg::PH_CHOOSE;
		end else if (round_q < PH2_START) begin
			phase = sha1bh_pkg::PH_PARITY;
		end else if (round_q < PH3_START) begin
			phase = sha1bh_pkg::PH_MAJ;
		end else begin
			phase = sha1bh_pkg::PH_PAR2;
		end
	end

	always_comb begin
		cmd.take   = take;
		cmd.close  = close;
		cmd.round  = (state_q == ST_RUN);
		cmd.phase  = phase;
		cmd.finish = finish;
	end

	// state machine and round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (close) begin
						state_q <= ST_RUN;
						round_q <= '0;
					end
				end
				ST_RUN: begin
					if (round_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end else begin
						round_q <= round_q + 1'b1;
					end
				end
				ST_ADD: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/sha1bh_dp.sv =====
// ----------------------------------------------------------------------------
// sha1bh_dp
// Datapath: block buffer and message schedule, round unit, chaining words and
// the output register.
// ----------------------------------------------------------------------------
module sha1bh_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  sha1bh_pkg::cmd_t   cmd,
	input  logic [7:0]         data_byte,
	input  logic               message_end,
	input  logic               restart,
	output sha1bh_pkg::sts_t   sts,
	output logic [31:0]        chain_a,
	output logic [31:0]        chain_b,
	output logic [31:0]        chain_c,
	output logic [31:0]        chain_d,
	output logic [31:0]        chain_e,
	output logic [63:0]        folded_digest,
	output logic               message_done
);

	localparam int WORDS = sha1bh_pkg::WORDS;

	logic [31:0]                       w_q [WORDS];
	logic [sha1bh_pkg::COUNT_W-1:0]    count_q;
	logic [31:0]                       h_q [5];
	logic [31:0]                       a_q, b_q, c_q, d_q, e_q;
	logic                              end_q;
	logic [31:0]                       w_next;
	logic [31:0]                       t_sum;
	logic [31:0]                       s0, s1, s2, s3, s4;
	logic [sha1bh_pkg::COUNT_W-1:0]    pos;
	logic [sha1bh_pkg::COUNT_W-3:0]    widx;
	logic [4:0]                        bofs;

	// byte position, restart discards the partial block
	assign pos  = restart ? '0 : count_q;
	assign widx = pos[sha1bh_pkg::COUNT_W-1:2];
	assign bofs = {~pos[1:0], 3'b000};

	assign sts.count_last = (pos == {sha1bh_pkg::COUNT_W{1'b1}});

	// schedule recurrence and round sum
	assign w_next = sha1bh_pkg::rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	assign t_sum  = sha1bh_pkg::rotl(a_q, 5) + sha1bh_pkg::round_f(cmd.phase, b_q, c_q, d_q)
		+ e_q + sha1bh_pkg::round_k(cmd.phase) + w_q[0];

	// chaining sums
	assign s0 = h_q[0] + a_q;
	assign s1 = h_q[1] + b_q;
	assign s2 = h_q[2] + c_q;
	assign s3 = h_q[3] + d_q;
	assign s4 = h_q[4] + e_q;

	// block buffer: byte packing, schedule shift, clear after compression
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORDS; i++) begin
				w_q[i] <= '0;
			end
			count_q <= '0;
		end else if (cmd.take) begin
			for (int i = 0; i < WORDS; i++) begin
				if (restart) begin
					w_q[i] <= '0;
				end
				if (widx == (sha1bh_pkg::COUNT_W-2)'(i)) begin
					w_q[i] <= (restart ? 32'd0 : w_q[i]) | ({24'd0, data_byte} << bofs);
				end
			end
			count_q <= cmd.close ? '0 : pos + 1'b1;
		end else if (cmd.round) begin
			for (int i = 0; i < WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[WORDS-1] <= w_next;
		end else if (cmd.finish) begin
			for (int i = 0; i < WORDS; i++) begin
				w_q[i] <= '0;
			end
		end
	end

	// chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= sha1bh_pkg::H0_INIT;
			h_q[1] <= sha1bh_pkg::H1_INIT;
			h_q[2] <= sha1bh_pkg::H2_INIT;
			h_q[3] <= sha1bh_pkg::H3_INIT;
			h_q[4] <= sha1bh_pkg::H4_INIT;
		end else if (cmd.take && restart) begin
			h_q[0] <= sha1bh_pkg::H0_INIT;
			h_q[1] <= sha1bh_pkg::H1_INIT;
			h_q[2] <= sha1bh_pkg::H2_INIT;
			h_q[3] <= sha1bh_pkg::H3_INIT;
			h_q[4] <= sha1bh_pkg::H4_INIT;
		end else if (cmd.finish) begin
			h_q[0] <= s0;
			h_q[1] <= s1;
			h_q[2] <= s2;
			h_q[3] <= s3;
			h_q[4] <= s4;
		end
	end

	// working words: load at block close, one round per cycle
	always_ff @(posedge clk) begin
		if (cmd.close) begin
			a_q   <= restart ? sha1bh_pkg::H0_INIT : h_q[0];
			b_q   <= restart ? sha1bh_pkg::H1_INIT : h_q[1];
			c_q   <= restart ? sha1bh_pkg::H2_INIT : h_q[2];
			d_q   <= restart ? sha1bh_pkg::H3_INIT : h_q[3];
			e_q   <= restart ? sha1bh_pkg::H4_INIT : h_q[4];
			end_q <= message_end;
		end else if (cmd.round) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= sha1bh_pkg::rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			chain_a       <= s0;
			chain_b       <= s1;
			chain_c       <= s2;
			chain_d       <= s3;
			chain_e       <= s4;
			folded_digest <= ({32'd0, s0} << 48) | ({32'd0, s1} << 36)
				| ({32'd0, s2} << 24) | ({32'd0, s3} << 12) | {32'd0, s4};
			message_done  <= end_q;
		end
	end

endmodule

// ===== sv/sha1_block_hash_top.sv =====
// ----------------------------------------------------------------------------
// sha1_block_hash_top
// Byte-serial SHA-1 compression engine with chaining words and a folded digest.
// ----------------------------------------------------------------------------
// Bytes that do not close a block are taken one byte per cycle while no block is
// being compressed. A closing byte starts the 80 rounds on the single round unit,
// then the sums are added into the chaining words and the output register; that
// add waits while an earlier result still sits unaccepted in the output register.
// No further byte is taken after the closing byte until that add is done.
// Reset loads the initial chaining values and clears the block buffer and
// byte count; no result is pending after reset.
// ----------------------------------------------------------------------------
module sha1_block_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        message_end,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] chain_a,
	output logic [31:0] chain_b,
	output logic [31:0] chain_c,
	output logic [31:0] chain_d,
	output logic [31:0] chain_e,
	output logic [63:0] folded_digest,
	output logic        message_done
);

	sha1bh_pkg::cmd_t cmd;
	sha1bh_pkg::sts_t sts;

	// sequencer
	sha1bh_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.message_end (message_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// buffer, rounds and chaining
	sha1bh_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.data_byte     (data_byte),
		.message_end   (message_end),
		.restart       (restart),
		.sts           (sts),
		.chain_a       (chain_a),
		.chain_b       (chain_b),
		.chain_c       (chain_c),
		.chain_d       (chain_d),
		.chain_e       (chain_e),
		.folded_digest (folded_digest),
		.message_done  (message_done)
	);

endmodule

// ===== tb/sv/sha1_block_hash_checker.sv =====
// ----------------------------------------------------------------------------
// sha1_block_hash_checker
// Watches both channels of the SHA-1 block hash engine, predicts every digest
// from the accepted requests, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module sha1_block_hash_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        message_end,
	input  logic        restart,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] chain_a,
	input  logic [31:0] chain_b,
	input  logic [31:0] chain_c,
	input  logic [31:0] chain_d,
	input  logic [31:0] chain_e,
	input  logic [63:0] folded_digest,
	input  logic        message_done,
	output int          mismatch_count,
	output int          digests_pending
);

	localparam int REPORT_LIMIT = 10;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t       a;
		word_t       b;
		word_t       c;
		word_t       d;
		word_t       e;
		logic [63:0] fold;
		logic        done;
	} digest_t;

	// predicted engine state
	word_t      chain_st [5];
	word_t      blk_st [16];
	logic [5:0] fill_cnt;
	digest_t    digest_q [$];
	int         errs;

	// left rotate taken from a doubled word
	function automatic word_t rol(input word_t x, input int n);
		logic [63:0] dbl;
		dbl = {x, x};
		return dbl[63 - n -: 32];
	endfunction

	function automatic void clear_block();
		for (int i = 0; i < 16; i++)
			blk_st[i] = '0;
		fill_cnt = '0;
	endfunction

	function automatic void load_initial_chain();
		chain_st[0] = sha1bh_pkg::H0_INIT;
		chain_st[1] = sha1bh_pkg::H1_INIT;
		chain_st[2] = sha1bh_pkg::H2_INIT;
		chain_st[3] = sha1bh_pkg::H3_INIT;
		chain_st[4] = sha1bh_pkg::H4_INIT;
	endfunction

	// 80 rounds over the buffered block, summed into the chaining words
	function automatic void compress_block_into_chain();
		word_t w [16];
		word_t a, b, c, d, e, f, k, t, wi;
		for (int i = 0; i < 16; i++)
			w[i] = blk_st[i];
		a = chain_st[0];
		b = chain_st[1];
		c = chain_st[2];
		d = chain_st[3];
		e = chain_st[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 16) begin
				wi = w[i];
			end else begin
				wi = rol(w[(i - 3) & 15] ^ w[(i - 8) & 15] ^ w[(i - 14) & 15] ^ w[i & 15], 1);
				w[i & 15] = wi;
			end
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = sha1bh_pkg::K_CHOOSE;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = sha1bh_pkg::K_PARITY;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1bh_pkg::K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = sha1bh_pkg::K_PAR2;
			end
			t = rol(a, 5) + f + e + k + wi;
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		chain_st[0] += a;
		chain_st[1] += b;
		chain_st[2] += c;
		chain_st[3] += d;
		chain_st[4] += e;
	endfunction

	// take one message byte; queue a digest when the block closes
	function automatic void absorb_byte(input logic [7:0] byte_in, input logic last,
		input logic fresh);
		digest_t dg;
		logic [5:0] pos;
		if (fresh) begin
			load_initial_chain();
			clear_block();
		end
		pos = fill_cnt;
		blk_st[pos[5:2]][31 - 8 * pos[1:0] -: 8] |= byte_in;
		fill_cnt = pos + 6'd1;
		if (pos == 6'd63 || last) begin
			compress_block_into_chain();
			clear_block();
			dg.a    = chain_st[0];
			dg.b    = chain_st[1];
			dg.c    = chain_st[2];
			dg.d    = chain_st[3];
			dg.e    = chain_st[4];
			dg.fold = ({32'd0, chain_st[0]} << 48) | ({32'd0, chain_st[1]} << 36) |
				({32'd0, chain_st[2]} << 24) | ({32'd0, chain_st[3]} << 12) |
				{32'd0, chain_st[4]};
			dg.done = last;
			digest_q.push_back(dg);
		end
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			errs++;
			if (errs <= REPORT_LIMIT)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endfunction

	// follow requests and results at each edge
	always @(posedge clk or negedge arst_n) begin
		digest_t want;
		if (!arst_n) begin
			load_initial_chain();
			clear_block();
			digest_q.delete();
			errs = 0;
			mismatch_count  <= 0;
			digests_pending <= 0;
		end else begin
			if (in_valid && in_ready)
				absorb_byte(data_byte, message_end, restart);
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					errs++;
					if (errs <= REPORT_LIMIT)
						$display("result with no digest predicted: fold %h", folded_digest);
				end else begin
					want = digest_q.pop_front();
					check_field("chain_a", {32'd0, want.a}, {32'd0, chain_a});
					check_field("chain_b", {32'd0, want.b}, {32'd0, chain_b});
					check_field("chain_c", {32'd0, want.c}, {32'd0, chain_c});
					check_field("chain_d", {32'd0, want.d}, {32'd0, chain_d});
					check_field("chain_e", {32'd0, want.e}, {32'd0, chain_e});
					check_field("folded_digest", want.fold, folded_digest);
					check_field("message_done", {63'd0, want.done}, {63'd0, message_done});
				end
			end
			mismatch_count  <= errs;
			digests_pending <= digest_q.size();
		end
	end

endmodule

// ===== tb/sv/sha1_block_hash_top_tb.sv =====
// ----------------------------------------------------------------------------
// sha1_block_hash_top_tb
// Feeds the SHA-1 block hash engine with short directed messages, then random
// messages of mixed lengths with random stalls on both sides; the checker
// predicts and compares every digest.
// ----------------------------------------------------------------------------
module sha1_block_hash_top_tb;

	localparam int ITEMS        = 1050;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int IDLE_PCT     = 27;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte   = '0;
	logic        message_end = 1'b0;
	logic        restart     = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [31:0] chain_a, chain_b, chain_c, chain_d, chain_e;
	logic [63:0] folded_digest;
	logic        message_done;
	int          mismatch_count;
	int          digests_pending;
	int          items_sent  = 0;
	int          cycles      = 0;
	logic        calm        = 1'b0;

	sha1_block_hash_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.message_end   (message_end),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.chain_a       (chain_a),
		.chain_b       (chain_b),
		.chain_c       (chain_c),
		.chain_d       (chain_d),
		.chain_e       (chain_e),
		.folded_digest (folded_digest),
		.message_done  (message_done)
	);

	sha1_block_hash_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.message_end     (message_end),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.chain_a         (chain_a),
		.chain_b         (chain_b),
		.chain_c         (chain_c),
		.chain_d         (chain_d),
		.chain_e         (chain_e),
		.folded_digest   (folded_digest),
		.message_done    (message_done),
		.mismatch_count  (mismatch_count),
		.digests_pending (digests_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side stalls, none during the calm stretch
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// present one request and hold it until accepted
	task automatic send_byte(input logic [7:0] byte_in, input logic last, input logic fresh);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= byte_in;
		message_end <= last;
		restart     <= fresh;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	initial begin
		int  pick;
		int  msg_len;
		bit  with_restart;
		bit  cut_short;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// restart and end on the same byte, lowest byte value
		send_byte(8'h00, 1'b1, 1'b1);
		// chaining carries on into a message without restart, highest byte value
		send_byte(8'hFF, 1'b1, 1'b0);
		// short message over every byte lane
		send_byte(8'hA5, 1'b0, 1'b1);
		send_byte(8'h5A, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h7F, 1'b1, 1'b0);
		// restart throws away a partial block
		send_byte(8'h11, 1'b0, 1'b1);
		send_byte(8'h22, 1'b0, 1'b0);
		send_byte(8'h33, 1'b0, 1'b0);
		send_byte(8'hC3, 1'b1, 1'b1);
		// unfinished bytes then a plain end without restart
		send_byte(8'hFE, 1'b0, 1'b0);
		send_byte(8'h00, 1'b1, 1'b0);

		// random messages, full blocks and block multiples among them
		while (items_sent < ITEMS) begin
			pick = $urandom_range(9);
			case (pick)
				0:       msg_len = 64;
				1:       msg_len = 128;
				2:       msg_len = $urandom_range(200, 65);
				default: msg_len = $urandom_range(63, 1);
			endcase
			with_restart = $urandom_range(99) < 85;
			cut_short    = $urandom_range(99) < 6;
			for (int j = 0; j < msg_len; j++) begin
				calm = (items_sent >= 400) && (items_sent < 600);
				if (cut_short && j == msg_len / 2)
					break;
				send_byte(8'($urandom_range(255)), j == msg_len - 1,
					(j == 0 && with_restart) || ($urandom_range(99) < 2));
			end
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		// drain outstanding digests, then watch for stray results
		do
			@(posedge clk);
		while (digests_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/sha1bh_pkg.sv
sv/sha1bh_ctrl.sv
sv/sha1bh_dp.sv
sv/sha1_block_hash_top.sv
tb/sv/sha1_block_hash_checker.sv
tb/sv/sha1_block_hash_top_tb.sv
